// ===== hdl/ndwd_pkg.sv =====
// Package with shared constants and types for the near-duplicate window detector.
`default_nettype none
package ndwd_pkg;

  localparam int unsigned MAX_SPAN   = 16;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned SPAN_W     = 5;
  localparam int unsigned TOL_W      = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SPAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [TOL_W-1:0]           tol_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/near_duplicate_window_detector.sv =====
// Top level of the near-duplicate window detector: cell chain, sticky flag, output register.
// A result is registered and appears in the cycle after its sample beat is accepted.
// Throughput: one sample per cycle while the input is not stalled; all window cells compare in parallel in that cycle.
// The output register frees as its result is taken, so input stalls only while it is held.
// Reset clears the cell valid bits, the sticky flag, the output valid and both registers.
// Kept sample values are not reset; entries that are not valid are never compared.
`default_nettype none
module near_duplicate_window_detector (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [ndwd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [ndwd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  ndwd_pkg::sample_t                   sample_i,
  input  wire                                 end_of_sequence_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic                                hit_o,
  output logic                                found_so_far_o,
  output logic                                closing_o
);
  import ndwd_pkg::*;

  logic [SPAN_W-1:0] span_q;
  tol_t              tol_q;
  logic              sticky_q, sticky_d;
  logic              out_valid_q;
  logic              hit_q, found_q, closing_q;

  logic              in_acc;
  logic              hit_any;
  logic              found_now;
  cell_ctrl_t        ctrl;

  sample_t           cell_value [MAX_SPAN+1];
  logic [MAX_SPAN:0] cell_valid;
  logic [MAX_SPAN-1:0] cell_hit;
  logic [MAX_SPAN-1:0] cell_en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
      tol_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WINDOW_SPAN: span_q <= cfg_data_i[SPAN_W-1:0];
        CFG_TOLERANCE:   tol_q  <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctrl.shift = in_acc && !end_of_sequence_i;
  assign ctrl.clear = in_acc && end_of_sequence_i;

  assign cell_value[0] = sample_i;
  assign cell_valid[0] = 1'b1;

  for (genvar g = 0; g < MAX_SPAN; g++) begin : g_cell
    assign cell_en[g] = (32'(span_q) > g);
    ndwd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_value_i (cell_value[g]),
      .prev_valid_i (cell_valid[g]),
      .probe_i      (sample_i),
      .tolerance_i  (tol_q),
      .enable_i     (cell_en[g]),
      .value_o      (cell_value[g+1]),
      .valid_o      (cell_valid[g+1]),
      .hit_o        (cell_hit[g])
    );
  end

  assign hit_any   = |cell_hit;
  assign found_now = sticky_q || hit_any;
  assign sticky_d  = end_of_sequence_i ? 1'b0 : found_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        sticky_q <= sticky_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hit_q     <= hit_any;
      found_q   <= found_now;
      closing_q <= end_of_sequence_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign found_so_far_o = found_q;
  assign closing_o      = closing_q;

  // An accepted beat always leaves a result waiting in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Closing a sequence empties the whole window and the sticky flag.
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_sequence_i) |=> (cell_valid[MAX_SPAN:1] == '0) && !sticky_q)
    else $error("window not cleared after closing beat");

  // A reported hit always shows in the sticky answer of the same result.
  a_hit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> found_so_far_o)
    else $error("hit without found_so_far");

  // Input is stalled only while a result is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

endmodule
`default_nettype wire

// ===== hdl/ndwd_cell.sv =====
// One window cell: holds a kept sample, passes it on, and compares it with the new sample.
`default_nettype none
module ndwd_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ndwd_pkg::cell_ctrl_t ctrl_i,
  input  ndwd_pkg::sample_t    prev_value_i,
  input  wire                  prev_valid_i,
  input  ndwd_pkg::sample_t    probe_i,
  input  ndwd_pkg::tol_t       tolerance_i,
  input  wire                  enable_i,
  output ndwd_pkg::sample_t    value_o,
  output logic                 valid_o,
  output logic                 hit_o
);
  import ndwd_pkg::*;

  sample_t value_q;
  logic    valid_q;
  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] tol_pos;
  logic signed [SAMPLE_W:0] tol_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= prev_value_i;
    end
  end

  always_comb begin
    diff    = {probe_i[SAMPLE_W-1], probe_i} - {value_q[SAMPLE_W-1], value_q};
    tol_pos = {2'b00, tolerance_i};
    tol_neg = -tol_pos;
    hit_o   = valid_q && enable_i && (diff <= tol_pos) && (diff >= tol_neg);
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== bench/tb_near_duplicate_window_detector.sv =====
// Self-checking testbench for the near-duplicate window detector, with a behavioral predictor.
`timescale 1ns / 100ps
module tb_near_duplicate_window_detector;
  import ndwd_pkg::*;

  typedef struct packed {
    logic hit;
    logic found;
    logic closing;
  } verdict_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_SPAN, ROW_TOL} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [31:0]       value;
    logic              closes;
    logic              typed;
    verdict_t          want;
  } row_t;

  localparam int PLAN_ROWS       = 24;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int HOLD_CYCLES     = 90;
  localparam int HOLD_AFTER      = 400;

  // A row either sends one sample or writes one register.
  row_t plan [PLAN_ROWS] = '{
    '{ROW_SAMPLE, 32'd5,         1'b0, 1'b1, 3'b000},
    '{ROW_SAMPLE, 32'd5,         1'b1, 1'b1, 3'b001},
    '{ROW_SPAN,   32'd16,        1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 3'b000},
    '{ROW_SAMPLE, 32'h7fff_ffff, 1'b0, 1'b1, 3'b000},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 3'b110},
    '{ROW_SAMPLE, 32'd7,         1'b1, 1'b1, 3'b011},
    '{ROW_SAMPLE, 32'd7,         1'b1, 1'b1, 3'b001},
    '{ROW_TOL,    32'hffff_ffff, 1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 3'b000},
    '{ROW_SAMPLE, 32'h7fff_ffff, 1'b0, 1'b1, 3'b000},
    '{ROW_SAMPLE, 32'd0,         1'b0, 1'b1, 3'b110},
    '{ROW_SAMPLE, 32'hffff_ffff, 1'b1, 1'b1, 3'b111},
    '{ROW_SPAN,   32'd1,         1'b0, 1'b0, 3'b000},
    '{ROW_TOL,    32'd3,         1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'd100,       1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'd200,       1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'd102,       1'b0, 1'b0, 3'b000},
    '{ROW_SPAN,   32'd3,         1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'd98,        1'b1, 1'b0, 3'b000},
    '{ROW_SPAN,   32'd31,        1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'd50,        1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'd53,        1'b0, 1'b0, 3'b000},
    '{ROW_SAMPLE, 32'd57,        1'b1, 1'b0, 3'b000}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_WINDOW_SPAN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  sample_t               sample_i = '0;
  logic                  end_of_sequence_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic                  found_so_far_o;
  logic                  closing_o;

  logic [SPAN_W-1:0]     span_cfg = '0;
  tol_t                  tol_cfg = '0;
  sample_t               kept [MAX_SPAN];
  int unsigned           kept_cnt = 0;
  int unsigned           kept_ptr = 0;
  logic                  seq_found = 1'b0;

  verdict_t              pending_verdicts [$];
  sample_t               recent [8];
  verdict_t              got_v;
  verdict_t              want_v;
  int                    fail_cnt = 0;
  int                    results_seen = 0;
  bit                    calm = 1'b0;
  bit                    hold_done = 1'b0;

  near_duplicate_window_detector dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .found_so_far_o    (found_so_far_o),
    .closing_o         (closing_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic verdict_t judge_sample(input sample_t s, input logic closes);
    int unsigned eff_span;
    int unsigned count;
    int unsigned slot;
    longint      diff;
    verdict_t    v;
    eff_span = (span_cfg > MAX_SPAN) ? MAX_SPAN : span_cfg;
    count = (eff_span < kept_cnt) ? eff_span : kept_cnt;
    v = '0;
    for (int unsigned d = 1; d <= count; d++) begin
      slot = (kept_ptr + MAX_SPAN - d) % MAX_SPAN;
      diff = longint'(s) - longint'(kept[slot]);
      if (diff < 0) diff = -diff;
      if (diff <= longint'(tol_cfg)) v.hit = 1'b1;
    end
    if (v.hit) seq_found = 1'b1;
    v.found = seq_found;
    v.closing = closes;
    if (closes) begin
      kept_cnt = 0;
      kept_ptr = 0;
      seq_found = 1'b0;
    end else begin
      kept[kept_ptr] = s;
      kept_ptr = (kept_ptr + 1) % MAX_SPAN;
      if (kept_cnt < MAX_SPAN) kept_cnt++;
    end
    return v;
  endfunction

  function automatic sample_t pick_sample();
    int unsigned pick;
    longint      mag;
    longint      v;
    pick = $urandom_range(0, 99);
    if (pick < 15) return sample_t'($urandom);
    if (pick < 25) begin
      case ($urandom_range(0, 3))
        0: return sample_t'(32'h8000_0000);
        1: return sample_t'(32'h7fff_ffff);
        2: return sample_t'(32'd0);
        default: return sample_t'(32'hffff_ffff);
      endcase
    end
    if (pick < 40) return recent[$urandom_range(0, 7)];
    mag = longint'($urandom) % (longint'(tol_cfg) + longint'(tol_cfg >> 2) + 3);
    v = longint'(recent[0]) + (($urandom_range(0, 1) == 1) ? mag : -mag);
    return sample_t'(v[31:0]);
  endfunction

  task automatic note_fail(input string what, input verdict_t want, input verdict_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t: %s: expected hit=%b found=%b closing=%b, got hit=%b found=%b closing=%b",
               $time, what, want.hit, want.found, want.closing, got.hit, got.found, got.closing);
  endtask

  task automatic offer(input sample_t s, input logic closes, input logic typed,
                       input verdict_t want);
    verdict_t v;
    cfg_valid_i <= 1'b0;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    end_of_sequence_i <= closes;
    do @(posedge clk_i); while (in_stall_o);
    v = judge_sample(s, closes);
    pending_verdicts.insert(pending_verdicts.size(), typed ? want : v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WINDOW_SPAN) span_cfg = data[SPAN_W-1:0];
    else if (idx == CFG_TOLERANCE) tol_cfg = data[TOL_W-1:0];
  endtask

  // The receiver stalls in bursts and holds off once for a long stretch so the block backs up.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_v = {hit_o, found_so_far_o, closing_o};
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        note_fail("result beat with no sample pending", '0, got_v);
      end else begin
        want_v = pending_verdicts.pop_front();
        if (got_v !== want_v) note_fail("result mismatch", want_v, got_v);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned seq_len;
    int unsigned seq_pos;
    logic        closes;
    sample_t     s;
    logic [CFG_DATA_W-1:0] tol_word;
    foreach (kept[i]) kept[i] = '0;
    foreach (recent[i]) recent[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_SPAN: begin
          drain();
          write_reg(CFG_WINDOW_SPAN, plan[i].value);
        end
        ROW_TOL: begin
          drain();
          write_reg(CFG_TOLERANCE, plan[i].value);
        end
        default: offer(sample_t'(plan[i].value), plan[i].closes, plan[i].typed, plan[i].want);
      endcase
    end

    seq_pos = 0;
    seq_len = $urandom_range(1, 20);
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph == PHASES - 1);
      case ($urandom_range(0, 5))
        0: write_reg(CFG_WINDOW_SPAN, 32'd0);
        1: write_reg(CFG_WINDOW_SPAN, MAX_SPAN);
        2: write_reg(CFG_WINDOW_SPAN, $urandom_range(MAX_SPAN + 1, 31));
        default: write_reg(CFG_WINDOW_SPAN, $urandom_range(1, MAX_SPAN));
      endcase
      case ($urandom_range(0, 5))
        0: tol_word = 32'd0;
        1: tol_word = 32'h7fff_ffff;
        2: tol_word = $urandom_range(1, 8);
        3: tol_word = $urandom_range(9, 100000);
        4: tol_word = $urandom;
        default: tol_word = $urandom_range(0, 1000);
      endcase
      write_reg(CFG_TOLERANCE, tol_word);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        closes = (seq_pos + 1 >= seq_len);
        s = pick_sample();
        offer(s, closes, 1'b0, '0);
        for (int k = 7; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = s;
        if (closes) begin
          seq_pos = 0;
          seq_len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 20);
        end else begin
          seq_pos++;
        end
      end
    end

    in_valid_i <= 1'b0;
    for (int k = 0; k < 10000 && pending_verdicts.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    fail_cnt += pending_verdicts.size();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ndwd_pkg.sv
hdl/ndwd_cell.sv
hdl/near_duplicate_window_detector.sv
bench/tb_near_duplicate_window_detector.sv
